/* rtl/fcog_pkg.sv */
// ----------------------------------------------------------------------------
// fcog_pkg
// Shared types, constants and lookup tables for the frame counter overlay
// pixel generator.
// ----------------------------------------------------------------------------
package fcog_pkg;

  localparam int X_W    = 11;
  localparam int Y_W    = 10;
  localparam int DIG_W  = 4;   // one decimal digit, also digit position/count
  localparam int TINT_W = 3;
  localparam int PIX_W  = 8;

  localparam logic [PIX_W-1:0] LUMA_BACK   = 8'd80;
  localparam logic [PIX_W-1:0] LUMA_STROKE = 8'd235;

  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int SCALE   = 4;
  localparam int GAP     = 2;
  localparam int MARGIN  = 8;
  localparam int PITCH   = GLYPH_W * SCALE + GAP;
  localparam int CELL_W  = GLYPH_W * SCALE;
  localparam int CELL_H  = GLYPH_H * SCALE;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int NUM_TINTS = 6;

  // 5x7 font, bit 4 is the leftmost column
  localparam logic [GLYPH_W-1:0] GLYPH_ROM [10][GLYPH_H] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
  };

  // red, green, blue, yellow, cyan, magenta
  localparam logic [PIX_W-1:0] TINT_CB [NUM_TINTS] = '{8'd90, 8'd54, 8'd240,
                                                      8'd16, 8'd166, 8'd166};
  localparam logic [PIX_W-1:0] TINT_CR [NUM_TINTS] = '{8'd240, 8'd34, 8'd110,
                                                      8'd146, 8'd16, 8'd240};

  // Classified pixel handed from front to back
  typedef struct packed {
    logic             hit;   // inside a glyph cell of some digit position
    logic [DIG_W-1:0] pos;   // digit position from the left
    logic [2:0]       row;   // font row 0..6
    logic [2:0]       col;   // font column 0..4
    logic             eof;
  } cls_t;

  function automatic logic [TINT_W-1:0] tint_wrap(input logic [TINT_W-1:0] sel);
    logic [TINT_W-1:0] res;
    res = (sel >= TINT_W'(NUM_TINTS)) ? sel - TINT_W'(NUM_TINTS) : sel;
    return res;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [DIG_W-1:0] digit,
                                                   input logic [2:0] row);
    logic [GLYPH_W-1:0] res;
    res = '0;
    if (digit <= DIG_W'(9) && row < 3'(GLYPH_H)) begin
      res = GLYPH_ROM[digit][row];
    end
    return res;
  endfunction

endpackage

/* rtl/fcog_if.sv */
// ----------------------------------------------------------------------------
// fcog channel interfaces
// Valid/ready channels for pixel requests, pixel results and tint writes.
// ----------------------------------------------------------------------------
interface fcog_in_if import fcog_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [X_W-1:0]   pixel_x;
  logic [Y_W-1:0]   pixel_y;
  logic             end_of_frame;

  modport source (output valid, pixel_x, pixel_y, end_of_frame, input ready);
  modport sink   (input valid, pixel_x, pixel_y, end_of_frame, output ready);
endinterface

interface fcog_out_if import fcog_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface fcog_cfg_if import fcog_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TINT_W-1:0] tint_select;

  modport source (output valid, tint_select, input ready);
  modport sink   (input valid, tint_select, output ready);
endinterface

/* rtl/fcog_front.sv */
// ----------------------------------------------------------------------------
// fcog_front
// Accepts pixel coordinates and classifies them against the digit grid.
// ----------------------------------------------------------------------------
module fcog_front import fcog_pkg::*; #(
  parameter int FRAME_WIDTH  = 1280,
  parameter int FRAME_HEIGHT = 720,
  parameter int DIGITS       = 10
) (
  fcog_in_if.sink    in_pix,
  input  logic       q_full,
  output logic       push,
  output cls_t       push_data
);

  localparam logic [12:0] FW = 13'(FRAME_WIDTH);
  localparam logic [12:0] FH = 13'(FRAME_HEIGHT);

  logic           in_frame;
  logic [X_W-1:0] rx;
  logic [Y_W-1:0] ry;
  logic [DIG_W-1:0] pos;
  logic [X_W-1:0] base;
  logic [X_W-1:0] cell_x;
  logic           hit;

  assign in_pix.ready = !q_full;
  assign push         = in_pix.valid && !q_full;

  assign in_frame = ({2'b00, in_pix.pixel_x} < FW) && ({3'b000, in_pix.pixel_y} < FH) &&
                    (in_pix.pixel_x >= X_W'(MARGIN)) && (in_pix.pixel_y >= Y_W'(MARGIN));
  assign rx = in_pix.pixel_x - X_W'(MARGIN);
  assign ry = in_pix.pixel_y - Y_W'(MARGIN);

  // Digit position by thresholds at multiples of the pitch; saturates at DIGITS
  always_comb begin
    pos  = '0;
    base = '0;
    for (int k = 1; k <= DIGITS; k++) begin
      if (rx >= X_W'(k * PITCH)) begin
        pos  = DIG_W'(k);
        base = X_W'(k * PITCH);
      end
    end
  end

  assign cell_x = rx - base;
  assign hit    = in_frame && (ry < Y_W'(CELL_H)) && (cell_x < X_W'(CELL_W)) &&
                  (pos < DIG_W'(DIGITS));

  always_comb begin
    push_data.hit = hit;
    push_data.pos = pos;
    push_data.row = 3'(ry[4:0] / SCALE);
    push_data.col = 3'(cell_x[4:0] / SCALE);
    push_data.eof = in_pix.end_of_frame;
  end

endmodule

/* rtl/fcog_queue.sv */
// ----------------------------------------------------------------------------
// fcog_queue
// Two-entry queue between classifier and renderer.
// ----------------------------------------------------------------------------
module fcog_queue import fcog_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cls_t head_data
);

  cls_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/fcog_back.sv */
// ----------------------------------------------------------------------------
// fcog_back
// Renders queued pixels against the frame counter and holds the result.
// ----------------------------------------------------------------------------
module fcog_back import fcog_pkg::*; #(
  parameter int DIGITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cls_t              head_data,
  output logic              pop,
  input  logic [TINT_W-1:0] tint_r,
  fcog_out_if.source        out_pix
);

  logic [DIG_W-1:0] cnt_r [DIGITS];
  logic [DIG_W-1:0] cnt_nxt [DIGITS];
  logic [DIG_W-1:0] sig_r, sig_nxt;
  logic             carry [DIGITS+1];

  logic             out_valid_r;
  logic [PIX_W-1:0] luma_r, cb_r, cr_r;

  logic [DIG_W-1:0]   idx;
  logic [DIG_W-1:0]   digit;
  logic [GLYPH_W-1:0] bits;
  logic               stroke;
  logic [TINT_W-1:0]  tint;

  assign pop = head_valid && (!out_valid_r || out_pix.ready);

  // Most significant digit on the left: position p shows digit sig-1-p
  always_comb begin
    idx   = sig_r - DIG_W'(1) - head_data.pos;
    digit = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (idx == DIG_W'(i)) begin
        digit = cnt_r[i];
      end
    end
    bits   = glyph_row(digit, head_data.row);
    stroke = head_data.hit && (head_data.pos < sig_r) &&
             bits[3'(GLYPH_W - 1) - head_data.col];
  end

  // Decimal increment; shown width grows when the carry passes the top shown digit, back to one on wrap
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      carry[i+1] = carry[i] && (cnt_r[i] >= DIG_W'(9));
      if (carry[i]) begin
        cnt_nxt[i] = (cnt_r[i] >= DIG_W'(9)) ? '0 : cnt_r[i] + DIG_W'(1);
      end else begin
        cnt_nxt[i] = cnt_r[i];
      end
    end
    if (carry[DIGITS]) begin
      sig_nxt = DIG_W'(1);
    end else if (carry[sig_r]) begin
      sig_nxt = sig_r + DIG_W'(1);
    end else begin
      sig_nxt = sig_r;
    end
  end

  assign tint = tint_wrap(tint_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r       <= DIG_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop && head_data.eof) begin
        sig_r <= sig_nxt;
        for (int i = 0; i < DIGITS; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      luma_r <= stroke ? LUMA_STROKE : LUMA_BACK;
      cb_r   <= TINT_CB[tint];
      cr_r   <= TINT_CR[tint];
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.luma        = luma_r;
  assign out_pix.chroma_blue = cb_r;
  assign out_pix.chroma_red  = cr_r;

endmodule

/* rtl/frame_counter_overlay_pixel_gen.sv */
// ----------------------------------------------------------------------------
// frame_counter_overlay_pixel_gen
// Test pattern pixel source with a decimal frame number overlay.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix  : pixel requests (pixel_x, pixel_y, end_of_frame), valid/ready.
//   out_pix : one result per request (luma, chroma_blue, chroma_red), in order.
//   cfg_wr  : tint_select write, always ready; write only while no pixel
//             is in flight.
// A request accepted on in_pix passes the combinational classifier into the
//   2-entry queue, then the render register once the output is free.
// Throughput: one pixel per clock sustained while out_pix.ready stays high;
//   the queue lets the input keep flowing while a result waits, until it fills.
// Stall: when out_pix.ready is low the result holds, the queue fills, and
//   in_pix.ready drops once both queue entries are used.
// Reset (rst_n low, synchronous): queue and output emptied, frame counter 0
//   showing one digit, tint red. The counter steps after the pixel that
//   carries end_of_frame leaves the queue, so later pixels see the new
//   number; it wraps to zero at 10^DIGITS.
// ----------------------------------------------------------------------------
module frame_counter_overlay_pixel_gen import fcog_pkg::*; #(
  parameter int FRAME_WIDTH  = 1280,
  parameter int FRAME_HEIGHT = 720,
  parameter int DIGITS       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  fcog_in_if.sink     in_pix,
  fcog_out_if.source  out_pix,
  fcog_cfg_if.sink    cfg_wr
);

  logic [TINT_W-1:0] tint_sel_r;

  logic q_push, q_full, q_pop, q_valid;
  cls_t q_in, q_head;

  // Tint register; the write port never stalls
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_sel_r <= '0;
    end else if (cfg_wr.valid) begin
      tint_sel_r <= cfg_wr.tint_select;
    end
  end

  // Front: geometry only, no dependence on counter state
  fcog_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .DIGITS       (DIGITS)
  ) u_front (
    .in_pix    (in_pix),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  fcog_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // Back: counter lookup, font, tint, output register
  fcog_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .tint_r     (tint_sel_r),
    .out_pix    (out_pix)
  );

endmodule

/* rtl/fcog_checker.sv */
// ----------------------------------------------------------------------------
// fcog_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fcog_checker import fcog_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] luma,
  input logic [PIX_W-1:0] cb,
  input logic [PIX_W-1:0] cr
);

  // Held result must not drop while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Nothing presented right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_luma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (luma == LUMA_BACK) || (luma == LUMA_STROKE))
    else $error("luma not background or stroke");

  a_tint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cb == 8'd90 && cr == 8'd240) || (cb == 8'd54 && cr == 8'd34) ||
                  (cb == 8'd240 && cr == 8'd110) || (cb == 8'd16 && cr == 8'd146) ||
                  (cb == 8'd166 && cr == 8'd16) || (cb == 8'd166 && cr == 8'd240))
    else $error("chroma pair is not a tint");

endmodule

bind frame_counter_overlay_pixel_gen fcog_checker u_fcog_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .luma      (out_pix.luma),
  .cb        (out_pix.chroma_blue),
  .cr        (out_pix.chroma_red)
);

/* dv/frame_counter_overlay_pixel_gen_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_counter_overlay_pixel_gen_test
// Self-checking bench for the frame counter overlay pixel generator. Pixel
// requests go in over valid/ready with random gaps, results are drained with
// random back-pressure, and each result is compared in order against a local
// model of the font, the decimal frame counter and the tint table. A short
// table of hand-picked pixels comes first, then random pixels clustered on
// the overlay, under every tint setting.
// ----------------------------------------------------------------------------
module frame_counter_overlay_pixel_gen_test;
  import fcog_pkg::*;

  localparam int FRAME_W    = 1280;
  localparam int FRAME_H    = 720;
  localparam int NUM_DIGITS = 10;

  // overlay geometry
  localparam int ORIGIN       = 8;   // left and top margin
  localparam int ZOOM         = 4;   // font scale
  localparam int GLYPH_SPAN_X = 20;  // 5 font columns * 4
  localparam int GLYPH_SPAN_Y = 28;  // 7 font rows * 4
  localparam int DIGIT_STEP   = 22;  // glyph plus 2 blank columns

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES  = 4;     // pipeline settle before a tint write
  localparam int TAIL_CYCLES   = 8;
  localparam int ITEMS_PER_SET = 168;

  typedef enum logic [TINT_W-1:0] {
    TINT_RED        = 3'd0,
    TINT_GREEN      = 3'd1,
    TINT_BLUE       = 3'd2,
    TINT_YELLOW     = 3'd3,
    TINT_CYAN       = 3'd4,
    TINT_MAGENTA    = 3'd5,
    TINT_WRAP_RED   = 3'd6,   // out of range, folds back to red
    TINT_WRAP_GREEN = 3'd7    // out of range, folds back to green
  } tint_e;

  // 5x7 font, bit 4 is the leftmost column
  localparam logic [4:0] FONT [10][7] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
  };

  localparam logic [PIX_W-1:0] CB_OF_TINT [6] = '{8'd90, 8'd54, 8'd240,
                                                 8'd16, 8'd166, 8'd166};
  localparam logic [PIX_W-1:0] CR_OF_TINT [6] = '{8'd240, 8'd34, 8'd110,
                                                 8'd146, 8'd16, 8'd240};

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
  } yuv_t;

  // one row of the hand-picked pixel table; typed rows carry their answer
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           eof;
    logic           typed;
    yuv_t           answer;
  } pixel_row_t;

  localparam yuv_t RED_BACK   = '{LUMA_BACK,   CB_OF_TINT[TINT_RED], CR_OF_TINT[TINT_RED]};
  localparam yuv_t RED_STROKE = '{LUMA_STROKE, CB_OF_TINT[TINT_RED], CR_OF_TINT[TINT_RED]};
  localparam yuv_t NO_ANSWER  = '0;

  // Counter is 0 showing one digit and the tint is red until the first eof row.
  localparam int NUM_ROWS = 19;
  localparam pixel_row_t PIXEL_TABLE [NUM_ROWS] = '{
    '{11'd0,    10'd0,    1'b0, 1'b1, RED_BACK},    // top left corner
    '{11'd8,    10'd8,    1'b0, 1'b1, RED_BACK},    // "0" row 0, left column blank
    '{11'd12,   10'd8,    1'b0, 1'b1, RED_STROKE},  // "0" row 0, top bar
    '{11'd8,    10'd12,   1'b0, 1'b1, RED_STROKE},  // "0" row 1, left edge
    '{11'd20,   10'd35,   1'b0, 1'b1, RED_STROKE},  // "0" bottom row, last line
    '{11'd27,   10'd35,   1'b0, 1'b1, RED_BACK},    // last glyph column, blank bit
    '{11'd28,   10'd12,   1'b0, 1'b1, RED_BACK},    // gap column
    '{11'd29,   10'd12,   1'b0, 1'b1, RED_BACK},    // gap column
    '{11'd30,   10'd12,   1'b0, 1'b1, RED_BACK},    // second position, not shown
    '{11'd12,   10'd36,   1'b0, 1'b1, RED_BACK},    // just below the glyph
    '{11'd7,    10'd12,   1'b0, 1'b1, RED_BACK},    // just left of the glyph
    '{11'd1279, 10'd719,  1'b0, 1'b1, RED_BACK},    // last pixel inside the frame
    '{11'd1280, 10'd8,    1'b0, 1'b1, RED_BACK},    // clipped column
    '{11'd12,   10'd720,  1'b0, 1'b1, RED_BACK},    // clipped row
    '{11'd2047, 10'd1023, 1'b0, 1'b1, RED_BACK},    // all ones
    '{11'd12,   10'd8,    1'b1, 1'b1, RED_STROKE},  // eof pixel still sees the old count
    '{11'd16,   10'd8,    1'b0, 1'b0, NO_ANSWER},   // "1" top
    '{11'd12,   10'd8,    1'b1, 1'b0, NO_ANSWER},   // eof on "1" row 0, blank bit
    '{11'd2047, 10'd0,    1'b1, 1'b0, NO_ANSWER}    // eof outside the frame
  };

  logic clk;
  logic rst_n;

  fcog_in_if  in_pix ();
  fcog_out_if out_pix ();
  fcog_cfg_if cfg_wr ();

  frame_counter_overlay_pixel_gen #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H),
    .DIGITS       (NUM_DIGITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .cfg_wr  (cfg_wr)
  );

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local copy of the block state: decimal frame count, digits shown, tint.
  // ---------------------------------------------------------------------------
  logic [3:0]        frame_digit [NUM_DIGITS];
  int                shown_digits;
  logic [TINT_W-1:0] tint_reg;

  yuv_t expected_pixels [$];
  int   mismatches;
  bit   no_idle;   // set for one stretch with neither side idling

  function automatic bit on_digit_stroke(input int x, input int y);
    int rx, ry, pos, cell_x, digit;
    if (x >= FRAME_W || y >= FRAME_H) return 1'b0;
    if (x < ORIGIN || y < ORIGIN) return 1'b0;
    ry = y - ORIGIN;
    if (ry >= GLYPH_SPAN_Y) return 1'b0;
    rx     = x - ORIGIN;
    pos    = rx / DIGIT_STEP;
    cell_x = rx % DIGIT_STEP;
    // blank columns between glyphs, and positions past the number
    if (cell_x >= GLYPH_SPAN_X) return 1'b0;
    if (pos >= shown_digits) return 1'b0;
    // leftmost position holds the most significant digit
    digit = frame_digit[shown_digits - 1 - pos];
    if (digit > 9) return 1'b0;
    return FONT[digit][ry / ZOOM][4 - cell_x / ZOOM];
  endfunction

  function automatic yuv_t render_pixel(input int x, input int y);
    yuv_t px;
    int   t;
    t       = tint_reg % 6;
    px.luma = on_digit_stroke(x, y) ? LUMA_STROKE : LUMA_BACK;
    px.cb   = CB_OF_TINT[t];
    px.cr   = CR_OF_TINT[t];
    return px;
  endfunction

  // decimal increment with wrap, then recount the digits on show
  function automatic void step_frame_count();
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (frame_digit[i] >= 4'd9) begin
        frame_digit[i] = 4'd0;
      end else begin
        frame_digit[i] = frame_digit[i] + 4'd1;
        break;
      end
    end
    shown_digits = 1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (frame_digit[i] != 4'd0) shown_digits = i + 1;
    end
  endfunction

  // idle span: mostly short, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic int send_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_span();
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Valid stays high across back-to-back transactions; the model
  // is stepped at the accepting edge, so each expectation sees every earlier
  // end_of_frame, which matches the in-order output.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                            input logic eof, input logic typed, input yuv_t answer);
    int   gap;
    yuv_t px;
    gap = send_gap();
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid        <= 1'b1;
    in_pix.pixel_x      <= x;
    in_pix.pixel_y      <= y;
    in_pix.end_of_frame <= eof;
    do @(posedge clk); while (!in_pix.ready);
    px = typed ? answer : render_pixel(x, y);
    expected_pixels.push_back(px);
    if (eof) step_frame_count();
  endtask

  // Tint writes only with nothing in flight: hold requests, drain, settle.
  task automatic write_tint(input tint_e tint);
    in_pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr.valid       <= 1'b1;
    cfg_wr.tint_select <= tint;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    tint_reg = tint;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, in-order compare.
  // ---------------------------------------------------------------------------
  int ready_left;

  always @(posedge clk) begin
    yuv_t want;
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
      ready_left    <= 0;
    end else begin
      if (out_pix.valid && out_pix.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel request pending");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pix.luma !== want.luma) begin
            $error("luma: expected %0d, got %0d", want.luma, out_pix.luma);
            mismatches++;
          end
          if (out_pix.chroma_blue !== want.cb) begin
            $error("chroma_blue: expected %0d, got %0d", want.cb, out_pix.chroma_blue);
            mismatches++;
          end
          if (out_pix.chroma_red !== want.cr) begin
            $error("chroma_red: expected %0d, got %0d", want.cr, out_pix.chroma_red);
            mismatches++;
          end
        end
      end
      if (ready_left > 0) begin
        ready_left <= ready_left - 1;
      end else if (no_idle || $urandom_range(0, 1) == 0) begin
        out_pix.ready <= 1'b1;
        ready_left    <= $urandom_range(1, 30);
      end else begin
        out_pix.ready <= 1'b0;
        ready_left    <= idle_span();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on any port ends the run.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam tint_e TINT_ORDER [8] = '{TINT_WRAP_GREEN, TINT_MAGENTA, TINT_RED,
                                      TINT_WRAP_RED, TINT_YELLOW, TINT_GREEN,
                                      TINT_CYAN, TINT_BLUE};

  initial begin
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           eof;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_pix.valid        = 1'b0;
    in_pix.pixel_x      = '0;
    in_pix.pixel_y      = '0;
    in_pix.end_of_frame = 1'b0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.tint_select  = '0;
    out_pix.ready       = 1'b0;
    quiet_cycles        = 0;
    mismatches          = 0;
    no_idle             = 1'b0;
    foreach (frame_digit[i]) frame_digit[i] = 4'd0;
    shown_digits = 1;
    tint_reg     = TINT_RED;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-picked pixels at the reset tint
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_pixel(PIXEL_TABLE[r].x, PIXEL_TABLE[r].y, PIXEL_TABLE[r].eof,
                 PIXEL_TABLE[r].typed, PIXEL_TABLE[r].answer);
    end

    // random pixels, one stretch per tint; each write drains the pipe first
    foreach (TINT_ORDER[p]) begin
      write_tint(TINT_ORDER[p]);
      no_idle = (p == 3);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if ($urandom_range(0, 99) < 80) begin
          // around the number as drawn now, one position past it
          x = X_W'($urandom_range(0, ORIGIN + DIGIT_STEP * (shown_digits + 1)));
          y = Y_W'($urandom_range(0, ORIGIN + GLYPH_SPAN_Y + 3));
        end else begin
          x = X_W'($urandom_range(0, (1 << X_W) - 1));
          y = Y_W'($urandom_range(0, (1 << Y_W) - 1));
        end
        eof = ($urandom_range(0, 2) == 0);
        send_pixel(x, y, eof, 1'b0, NO_ANSWER);
      end
      no_idle = 1'b0;
    end

    in_pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fcog_pkg.sv
rtl/fcog_if.sv
rtl/fcog_front.sv
rtl/fcog_queue.sv
rtl/fcog_back.sv
rtl/frame_counter_overlay_pixel_gen.sv
rtl/fcog_checker.sv
dv/frame_counter_overlay_pixel_gen_test.sv
